@@ rtl/core/rfp_pkg.sv @@
// rfp_pkg: shared types and constants for the record frame parser
// result item layout, status codes, output queue sizing and record limit
// no dependencies
`default_nettype none

package rfp_pkg;

    localparam int unsigned MAX_RECORDS = 32;
    localparam int unsigned QDEPTH      = 4;
    localparam int unsigned QAW         = $clog2(QDEPTH);
    localparam int unsigned QCW         = $clog2(QDEPTH + 1);

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_EMPTY     = 3'd1;
    localparam logic [2:0] ST_TRUNC     = 3'd2;
    localparam logic [2:0] ST_BAD_LEN   = 3'd3;
    localparam logic [2:0] ST_SIZE_LOW  = 3'd4;
    localparam logic [2:0] ST_PARTIAL   = 3'd5;

    localparam logic KIND_RECORD = 1'b0;
    localparam logic KIND_FINAL  = 1'b1;

    typedef struct packed {
        logic        result_kind;
        logic [2:0]  status;
        logic [7:0]  frame_type;
        logic [31:0] frame_len;
        logic [31:0] header_word;
        logic [7:0]  rec_total;
        logic [7:0]  unknown_count;
        logic [32:0] used_bytes;
        logic [31:0] rec_size;
        logic [15:0] rec_code;
        logic [32:0] body_offset;
        logic        code_known;
    } t_result;

    // results produced by one accepted byte, record first
    typedef struct packed {
        logic    rec_vld;
        logic    fin_vld;
        t_result rec;
        t_result fin;
    } t_push;

    function automatic logic code_is_known(input logic [15:0] code);
        return ((code >= 16'd2) && (code <= 16'd10)) || (code == 16'd15);
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/rfp_parse.sv @@
// rfp_parse: byte-serial frame parser state and result formation
// depends on rfp_pkg
`default_nettype none

module rfp_parse (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire logic [7:0]    i_data_byte,
    input  wire logic          i_has_byte,
    input  wire logic          i_last_byte,
    output rfp_pkg::t_push     o_push
);
    import rfp_pkg::*;

    typedef enum logic [2:0] {
        PH_TYPE, PH_LEN, PH_HDR, PH_SIZE, PH_CODE, PH_BODY, PH_DONE
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [32:0] r_pos, n_pos;
    logic [7:0]  r_type, n_type;
    logic [31:0] r_len, n_len;
    logic [31:0] r_hdr, n_hdr;
    logic [31:0] r_acc, n_acc;
    logic [1:0]  r_cnt, n_cnt;
    logic [15:0] r_code, n_code;
    logic        r_code_first, n_code_first;
    logic [32:0] r_nrs, n_nrs;
    logic [7:0]  r_records, n_records;
    logic [7:0]  r_unknown, n_unknown;
    logic [2:0]  r_held, n_held;

    logic [33:0] pos_inc;
    logic [33:0] frame_end;
    logic [31:0] acc_shift;
    logic [33:0] size_end;
    logic [15:0] code_full;
    logic        known;
    logic [7:0]  rec_inc;
    logic [33:0] start_p;
    logic [7:0]  start_recs;
    logic        start_ok;
    logic [33:0] fin_end;
    t_push       push;

    always_comb begin
        pos_inc    = {1'b0, r_pos} + 34'd1;
        frame_end  = {2'b00, r_len} + 34'd5;
        acc_shift  = {r_acc[23:0], i_data_byte};
        size_end   = pos_inc + {2'b00, acc_shift};
        code_full  = {r_code[7:0], i_data_byte};
        known      = code_is_known(code_full);
        rec_inc    = r_records + 8'd1;
        // next record starts at p only if six more bytes fit: p+6 <= 5+L
        start_p    = (r_phase == PH_HDR) ? 34'd9 : pos_inc;
        start_recs = (r_phase == PH_CODE) ? rec_inc : r_records;
        start_ok   = (start_p < {2'b00, r_len}) && (start_recs < 8'(MAX_RECORDS));

        n_phase      = r_phase;
        n_pos        = r_pos;
        n_type       = r_type;
        n_len        = r_len;
        n_hdr        = r_hdr;
        n_acc        = r_acc;
        n_cnt        = r_cnt;
        n_code       = r_code;
        n_code_first = r_code_first;
        n_nrs        = r_nrs;
        n_records    = r_records;
        n_unknown    = r_unknown;
        n_held       = r_held;

        push     = '0;

        if (i_has_byte) begin
            unique case (r_phase)
                PH_TYPE: begin
                    n_type  = i_data_byte;
                    n_acc   = '0;
                    n_cnt   = '0;
                    n_phase = PH_LEN;
                end
                PH_LEN: begin
                    n_acc = acc_shift;
                    n_cnt = r_cnt + 2'd1;
                    if (r_cnt == 2'd3) begin
                        n_len   = acc_shift;
                        n_acc   = '0;
                        n_phase = (acc_shift < 32'd4) ? PH_DONE : PH_HDR;
                    end
                end
                PH_HDR: begin
                    n_acc = acc_shift;
                    n_cnt = r_cnt + 2'd1;
                    if (r_cnt == 2'd3) begin
                        n_hdr = acc_shift;
                        if (start_ok) begin
                            n_nrs   = start_p[32:0];
                            n_acc   = '0;
                            n_phase = PH_SIZE;
                        end else begin
                            n_phase = PH_DONE;
                        end
                    end
                end
                PH_SIZE: begin
                    n_acc = acc_shift;
                    n_cnt = r_cnt + 2'd1;
                    if (r_cnt == 2'd3) begin
                        if (acc_shift < 32'd2) begin
                            n_held  = ST_SIZE_LOW;
                            n_phase = PH_DONE;
                        end else if (size_end > frame_end) begin
                            n_held  = ST_PARTIAL;
                            n_phase = PH_DONE;
                        end else begin
                            n_nrs        = size_end[32:0];
                            n_code       = '0;
                            n_code_first = 1'b1;
                            n_phase      = PH_CODE;
                        end
                    end
                end
                PH_CODE: begin
                    if (r_code_first) begin
                        n_code       = {8'h00, i_data_byte};
                        n_code_first = 1'b0;
                    end else begin
                        n_code    = code_full;
                        n_records = rec_inc;
                        if (!known) begin
                            n_unknown = r_unknown + 8'd1;
                        end
                        push.rec_vld          = 1'b1;
                        push.rec.result_kind  = KIND_RECORD;
                        push.rec.rec_size     = r_acc;
                        push.rec.rec_code     = code_full;
                        push.rec.body_offset  = pos_inc[32:0];
                        push.rec.code_known   = known;
                        // empty body: the next record begins right away
                        if ({1'b0, r_nrs} == pos_inc) begin
                            if (start_ok) begin
                                n_nrs   = start_p[32:0];
                                n_acc   = '0;
                                n_cnt   = '0;
                                n_phase = PH_SIZE;
                            end else begin
                                n_phase = PH_DONE;
                            end
                        end else begin
                            n_phase = PH_BODY;
                        end
                    end
                end
                PH_BODY: begin
                    if ({1'b0, r_nrs} == pos_inc) begin
                        if (start_ok) begin
                            n_nrs   = start_p[32:0];
                            n_acc   = '0;
                            n_cnt   = '0;
                            n_phase = PH_SIZE;
                        end else begin
                            n_phase = PH_DONE;
                        end
                    end
                end
                PH_DONE: begin
                end
                default: begin
                    n_phase = PH_DONE;
                end
            endcase
            // position saturates at all ones
            if (r_pos != '1) begin
                n_pos = pos_inc[32:0];
            end
        end

        fin_end = {2'b00, n_len} + 34'd5;
        if (i_last_byte) begin
            push.fin_vld          = 1'b1;
            push.fin.result_kind  = KIND_FINAL;
            if (n_pos == '0) begin
                push.fin.status = ST_EMPTY;
            end else if (n_pos < 33'd5) begin
                push.fin.status = ST_TRUNC;
            end else begin
                push.fin.frame_type = n_type;
                push.fin.frame_len  = n_len;
                if (fin_end > {1'b0, n_pos}) begin
                    push.fin.status = ST_BAD_LEN;
                end else if (n_len < 32'd4) begin
                    push.fin.status = ST_TRUNC;
                end else begin
                    push.fin.status        = n_held;
                    push.fin.header_word   = n_hdr;
                    push.fin.rec_total     = n_records;
                    push.fin.unknown_count = n_unknown;
                    push.fin.used_bytes    =
                        (n_held == ST_OK) ? fin_end[32:0] : 33'd0;
                end
            end
            // frame ends: back to the reset state
            n_phase      = PH_TYPE;
            n_pos        = '0;
            n_type       = '0;
            n_len        = '0;
            n_hdr        = '0;
            n_acc        = '0;
            n_cnt        = '0;
            n_code       = '0;
            n_code_first = 1'b0;
            n_nrs        = '0;
            n_records    = '0;
            n_unknown    = '0;
            n_held       = ST_OK;
        end

        o_push         = push;
        o_push.rec_vld = push.rec_vld & i_accept;
        o_push.fin_vld = push.fin_vld & i_accept;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_TYPE;
            r_pos        <= '0;
            r_type       <= '0;
            r_len        <= '0;
            r_hdr        <= '0;
            r_acc        <= '0;
            r_cnt        <= '0;
            r_code       <= '0;
            r_code_first <= 1'b0;
            r_nrs        <= '0;
            r_records    <= '0;
            r_unknown    <= '0;
            r_held       <= ST_OK;
        end else if (i_accept) begin
            r_phase      <= n_phase;
            r_pos        <= n_pos;
            r_type       <= n_type;
            r_len        <= n_len;
            r_hdr        <= n_hdr;
            r_acc        <= n_acc;
            r_cnt        <= n_cnt;
            r_code       <= n_code;
            r_code_first <= n_code_first;
            r_nrs        <= n_nrs;
            r_records    <= n_records;
            r_unknown    <= n_unknown;
            r_held       <= n_held;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/rfp_queue.sv @@
// rfp_queue: small result queue, takes up to two results per cycle, gives one
// depends on rfp_pkg
`default_nettype none

module rfp_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire rfp_pkg::t_push    i_push,
    output logic                   o_room,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output rfp_pkg::t_result       o_head
);
    import rfp_pkg::*;

    t_result           r_mem [QDEPTH];
    logic [QAW-1:0]    r_head, n_head;
    logic [QAW-1:0]    r_tail, n_tail;
    logic [QCW-1:0]    r_count, n_count;

    logic              wr0, wr1, pop;
    t_result           d0;

    always_comb begin
        wr0 = i_push.rec_vld | i_push.fin_vld;
        wr1 = i_push.rec_vld & i_push.fin_vld;
        d0  = i_push.rec_vld ? i_push.rec : i_push.fin;
        pop = (r_count != '0) & i_out_ready;

        n_head  = pop ? r_head + QAW'(1) : r_head;
        n_tail  = r_tail + QAW'(wr0) + QAW'(wr1);
        n_count = r_count + QCW'(wr0) + QCW'(wr1) - QCW'(pop);

        // room for the worst case of two results from one byte
        o_room      = (r_count <= QCW'(QDEPTH - 2));
        o_out_valid = (r_count != '0);
        o_head      = r_mem[r_head];
    end

    always_ff @(posedge i_clk) begin
        if (wr0) begin
            r_mem[r_tail] <= d0;
        end
        if (wr1) begin
            r_mem[r_tail + QAW'(1)] <= i_push.fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/record_frame_parser.sv @@
// record_frame_parser: top level, byte-serial frame parser with result queue
// depends on rfp_pkg, rfp_parse, rfp_queue
`default_nettype none

// Takes one frame byte per transfer and can accept a byte every cycle. A frame
// is a type byte, a big-endian 32-bit payload length, a 32-bit header word and
// records (32-bit size, 16-bit event code, body). A record result goes out when
// a record's second code byte arrives; a final result follows the transfer
// marked last, after which the parser is back in its reset state. Each byte is
// handled in the cycle it is taken and its results land in a four-entry queue
// the same cycle, so a result can be taken in the cycle after its byte. Input
// ready stays high while the queue has room for two results, so with the
// output side taking a result per cycle the block runs at one byte per cycle.

module record_frame_parser (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_has_byte,
    input  wire logic        i_last_byte,

    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_result_kind,
    output logic [2:0]       o_status,
    output logic [7:0]       o_frame_type,
    output logic [31:0]      o_frame_len,
    output logic [31:0]      o_header_word,
    output logic [7:0]       o_rec_total,
    output logic [7:0]       o_unknown_count,
    output logic [32:0]      o_used_bytes,
    output logic [31:0]      o_rec_size,
    output logic [15:0]      o_rec_code,
    output logic [32:0]      o_body_offset,
    output logic             o_code_known
);
    import rfp_pkg::*;

    logic    room;
    logic    accept;
    t_push   push;
    t_result head;

    assign o_in_ready = room;
    assign accept     = i_in_valid & room;

    rfp_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .i_has_byte  (i_has_byte),
        .i_last_byte (i_last_byte),
        .o_push      (push)
    );

    rfp_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_room      (room),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_head      (head)
    );

    assign o_result_kind    = head.result_kind;
    assign o_status         = head.status;
    assign o_frame_type     = head.frame_type;
    assign o_frame_len      = head.frame_len;
    assign o_header_word    = head.header_word;
    assign o_rec_total      = head.rec_total;
    assign o_unknown_count  = head.unknown_count;
    assign o_used_bytes     = head.used_bytes;
    assign o_rec_size       = head.rec_size;
    assign o_rec_code       = head.rec_code;
    assign o_body_offset    = head.body_offset;
    assign o_code_known     = head.code_known;

endmodule

`default_nettype wire
